// ===== rtl/core/two_wire_humidity_sensor_master_unit_assert.svh =====
// Assertion macros used by the sensor master sequencer
`ifndef TWO_WIRE_HUMIDITY_SENSOR_MASTER_UNIT_ASSERT_SVH
`define TWO_WIRE_HUMIDITY_SENSOR_MASTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define THSM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("thsm assertion failed");

// next-cycle implication, checked outside reset
`define THSM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("thsm assertion failed");

`endif

// ===== rtl/core/thsm_pkg.sv =====
// Package: types, codes and constants of the two-wire sensor master
package thsm_pkg;

    localparam int RESET_PULSES = 9;
    localparam int READ_BYTES   = 2;

    localparam logic [3:0] RESET_PULSES_C = 4'(RESET_PULSES);
    localparam logic [4:0] READ_BYTES_C   = 5'(READ_BYTES);

    // start pattern, bit k is tick k
    localparam logic [6:0] TS_SCK_PAT = 7'b0110110;
    localparam logic [6:0] TS_SDA_PAT = 7'b1100011;

    localparam logic [1:0] REG_TEMP_CMD     = 2'd0;
    localparam logic [1:0] REG_HUMID_CMD    = 2'd1;
    localparam logic [1:0] REG_STATUS_CMD   = 2'd2;
    localparam logic [1:0] REG_SOFT_RST_CMD = 2'd3;

    localparam logic [2:0] OP_TEMP       = 3'd0;
    localparam logic [2:0] OP_HUMID      = 3'd1;
    localparam logic [2:0] OP_WR_STATUS  = 3'd2;
    localparam logic [2:0] OP_SOFT_RESET = 3'd3;
    localparam logic [2:0] OP_CONN_RESET = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_CR_SETUP = 5'd1,
        PH_CR_HIGH  = 5'd2,
        PH_CR_LOW   = 5'd3,
        PH_TS0      = 5'd4,
        PH_TS1      = 5'd5,
        PH_TS2      = 5'd6,
        PH_TS3      = 5'd7,
        PH_TS4      = 5'd8,
        PH_TS5      = 5'd9,
        PH_TS6      = 5'd10,
        PH_WB_SET   = 5'd11,
        PH_WB_HIGH  = 5'd12,
        PH_ACK_LOW  = 5'd13,
        PH_ACK_HIGH = 5'd14,
        PH_ACK_END  = 5'd15,
        PH_WAIT     = 5'd16,
        PH_RB_HIGH  = 5'd17,
        PH_RB_LOW   = 5'd18,
        PH_RA_SET   = 5'd19,
        PH_RA_HIGH  = 5'd20,
        PH_RA_LOW   = 5'd21
    } phase_t;

    typedef struct packed {
        logic [7:0] temp_cmd;
        logic [7:0] humid_cmd;
        logic [7:0] status_cmd;
        logic [7:0] soft_rst_cmd;
    } cfg_t;

    typedef struct packed {
        logic        start_req;
        logic [2:0]  opcode;
        logic [7:0]  status_value;
        logic        sda_sample;
    } req_t;

    typedef struct packed {
        logic        sck_level;
        logic        sda_drive_enable;
        logic        sda_drive_level;
        logic        busy_res;
        logic        done_res;
        logic [15:0] reading;
        logic [1:0]  missing_acks;
    } result_t;

endpackage

// ===== rtl/core/two_wire_humidity_sensor_master_unit.sv =====
// Top level of the two-wire humidity sensor master
//  port group | handshake         | carries
//  cfg_*      | cfg_wr_en         | command code registers 0..3
//  s_*        | s_valid / s_ready | one bus tick: request, opcode, status byte, SDA sample
//  m_*        | m_valid / m_ready | pin levels, busy, done, reading, missing acks
// One tick is taken per cycle while s_ready is high; each tick's result appears in the
// result register in the next cycle. The sequencer state updates only on an accepted
// tick, so the bus timing follows the tick rate. s_ready drops only while a result is
// held and m_ready is low. Reset is synchronous and active low; it returns the
// sequencer to idle and restores the default command codes.
module two_wire_humidity_sensor_master_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_status_value,
    input  logic        s_sda_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sck_level,
    output logic        m_sda_drive_enable,
    output logic        m_sda_drive_level,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [15:0] m_reading,
    output logic [1:0]  m_missing_acks
);
    import thsm_pkg::*;

    cfg_t    cfg;
    req_t    req;
    result_t res;
    result_t m_res;
    logic    step;

    assign req.start_req    = s_start_req;
    assign req.opcode       = s_opcode;
    assign req.status_value = s_status_value;
    assign req.sda_sample   = s_sda_sample;

    assign step = s_valid && s_ready;

    thsm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    thsm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (req),
        .cfg     (cfg),
        .res     (res)
    );

    thsm_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .res     (res),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_sck_level        = m_res.sck_level;
    assign m_sda_drive_enable = m_res.sda_drive_enable;
    assign m_sda_drive_level  = m_res.sda_drive_level;
    assign m_busy_res         = m_res.busy_res;
    assign m_done_res         = m_res.done_res;
    assign m_reading          = m_res.reading;
    assign m_missing_acks     = m_res.missing_acks;

endmodule

// ===== rtl/core/thsm_cfg_regs.sv =====
// Command code registers written through the configuration port
module thsm_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [7:0]    cfg_wdata,
    output thsm_pkg::cfg_t cfg
);
    import thsm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_cmd     <= 8'd3;
            cfg_reg.humid_cmd    <= 8'd5;
            cfg_reg.status_cmd   <= 8'd6;
            cfg_reg.soft_rst_cmd <= 8'd30;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TEMP_CMD:     cfg_reg.temp_cmd     <= cfg_wdata;
                REG_HUMID_CMD:    cfg_reg.humid_cmd    <= cfg_wdata;
                REG_STATUS_CMD:   cfg_reg.status_cmd   <= cfg_wdata;
                REG_SOFT_RST_CMD: cfg_reg.soft_rst_cmd <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/thsm_seq.sv =====
// Waveform sequencer: one bus step per accepted tick
module thsm_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  thsm_pkg::req_t    req,
    input  thsm_pkg::cfg_t    cfg,
    output thsm_pkg::result_t res
);
    import thsm_pkg::*;

    `include "two_wire_humidity_sensor_master_unit_assert.svh"

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_pos_reg, bit_pos_next;
    logic [15:0] shift_reg, shift_next;
    logic [1:0]  nack_reg, nack_next;
    logic [2:0]  op_reg, op_next;
    logic [3:0]  pulse_cnt_reg, pulse_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_pos_reg   <= '0;
            shift_reg     <= '0;
            nack_reg      <= '0;
            op_reg        <= '0;
            pulse_cnt_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bit_pos_reg   <= bit_pos_next;
            shift_reg     <= shift_next;
            nack_reg      <= nack_next;
            op_reg        <= op_next;
            pulse_cnt_reg <= pulse_cnt_next;
        end
    end

    always_comb begin
        phase_t     ph;
        logic [2:0] k;
        logic [3:0] pc_inc;
        logic [3:0] bp_inc;
        logic [4:0] pc_plus;

        phase_next     = phase_reg;
        bit_pos_next   = bit_pos_reg;
        shift_next     = shift_reg;
        nack_next      = nack_reg;
        op_next        = op_reg;
        pulse_cnt_next = pulse_cnt_reg;
        res            = '0;

        // take a request only while idle and only for a known opcode
        if (phase_reg == PH_IDLE && req.start_req && req.opcode <= OP_CONN_RESET) begin
            op_next        = req.opcode;
            nack_next      = '0;
            pulse_cnt_next = '0;
            bit_pos_next   = '0;
            case (req.opcode)
                OP_TEMP:       shift_next = {cfg.temp_cmd, 8'h00};
                OP_HUMID:      shift_next = {cfg.humid_cmd, 8'h00};
                OP_WR_STATUS:  shift_next = {cfg.status_cmd, req.status_value};
                OP_SOFT_RESET: shift_next = {cfg.soft_rst_cmd, 8'h00};
                default:       shift_next = '0;
            endcase
            phase_next = (req.opcode >= OP_SOFT_RESET) ? PH_CR_SETUP : PH_TS0;
        end

        ph      = phase_next;
        k       = 3'(ph - PH_TS0);
        pc_inc  = pulse_cnt_next + 4'd1;
        bp_inc  = bit_pos_next + 4'd1;
        pc_plus = {1'b0, pulse_cnt_next} + 5'd1;

        res.busy_res = (ph != PH_IDLE);

        case (ph)
            PH_IDLE: ;
            PH_CR_SETUP: begin
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = 1'b1;
                phase_next           = PH_CR_HIGH;
            end
            PH_CR_HIGH: begin
                res.sck_level        = 1'b1;
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = 1'b1;
                phase_next           = PH_CR_LOW;
            end
            PH_CR_LOW: begin
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = 1'b1;
                if (pc_inc >= RESET_PULSES_C) begin
                    pulse_cnt_next = '0;
                    phase_next     = PH_TS0;
                end else begin
                    pulse_cnt_next = pc_inc;
                    phase_next     = PH_CR_HIGH;
                end
            end
            PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6: begin
                res.sck_level        = TS_SCK_PAT[k];
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = TS_SDA_PAT[k];
                if (ph != PH_TS6) begin
                    phase_next = phase_t'(ph + 5'd1);
                end else if (op_next == OP_CONN_RESET) begin
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                end else begin
                    bit_pos_next = '0;
                    phase_next   = PH_WB_SET;
                end
            end
            PH_WB_SET: begin
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = shift_next[15];
                phase_next           = PH_WB_HIGH;
            end
            PH_WB_HIGH: begin
                res.sck_level        = 1'b1;
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = shift_next[15];
                shift_next           = {shift_next[14:0], 1'b0};
                if (bp_inc >= 4'd8) begin
                    bit_pos_next = '0;
                    phase_next   = PH_ACK_LOW;
                end else begin
                    bit_pos_next = bp_inc;
                    phase_next   = PH_WB_SET;
                end
            end
            PH_ACK_LOW: phase_next = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
                res.sck_level = 1'b1;
                if (req.sda_sample && nack_next != 2'd3) begin
                    nack_next = nack_next + 2'd1;
                end
                phase_next = PH_ACK_END;
            end
            PH_ACK_END: begin
                // status write sends its value byte after the command byte
                if (op_next == OP_WR_STATUS && pulse_cnt_next == 4'd0) begin
                    pulse_cnt_next = 4'd1;
                    bit_pos_next   = '0;
                    phase_next     = PH_WB_SET;
                end else if (op_next <= OP_HUMID) begin
                    phase_next = PH_WAIT;
                end else begin
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            PH_WAIT: begin
                if (!req.sda_sample) begin
                    bit_pos_next   = '0;
                    pulse_cnt_next = '0;
                    phase_next     = PH_RB_HIGH;
                end
            end
            PH_RB_HIGH: begin
                res.sck_level = 1'b1;
                shift_next    = {shift_next[14:0], req.sda_sample};
                bit_pos_next  = bp_inc;
                phase_next    = PH_RB_LOW;
            end
            PH_RB_LOW: begin
                if (bit_pos_next >= 4'd8) begin
                    bit_pos_next = '0;
                    phase_next   = PH_RA_SET;
                end else begin
                    phase_next = PH_RB_HIGH;
                end
            end
            PH_RA_SET: begin
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = (pc_plus >= READ_BYTES_C);
                phase_next           = PH_RA_HIGH;
            end
            PH_RA_HIGH: begin
                res.sck_level        = 1'b1;
                res.sda_drive_enable = 1'b1;
                res.sda_drive_level  = (pc_plus >= READ_BYTES_C);
                phase_next           = PH_RA_LOW;
            end
            PH_RA_LOW: begin
                pulse_cnt_next = pc_inc;
                if ({1'b0, pc_inc} >= READ_BYTES_C) begin
                    res.done_res = 1'b1;
                    res.reading  = shift_next;
                    phase_next   = PH_IDLE;
                end else begin
                    bit_pos_next = '0;
                    phase_next   = PH_RB_HIGH;
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        if (res.done_res) begin
            res.missing_acks = nack_next;
        end
    end

    `THSM_ASSERT_IMP(a_done_busy, step && res.done_res, res.busy_res)
    `THSM_ASSERT_IMP(a_reading_on_done, step && (res.reading != 16'd0), res.done_res)
    `THSM_ASSERT_NXT(a_done_idle, step && res.done_res, phase_reg == PH_IDLE)
    `THSM_ASSERT_IMP(a_acks_on_done, step && (res.missing_acks != 2'd0), res.done_res)

endmodule

// ===== rtl/core/thsm_out_reg.sv =====
// Result register between the sequencer and the result channel
module thsm_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  thsm_pkg::result_t res,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output thsm_pkg::result_t m_res
);
    import thsm_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // refill in the same cycle the held transaction drains
    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule
